FILE: src/luma_area_downscaler_macros.svh
`ifndef LUMA_AREA_DOWNSCALER_MACROS_SVH
`define LUMA_AREA_DOWNSCALER_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define LDS_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LDS_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lds_pkg.sv
`timescale 1ns / 1ps
package lds_pkg;
    localparam int MAX_SRC_DIM   = 4096;
    localparam int MAX_OUT_WIDTH = 512;

    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int OCOL_W  = 9;
    localparam int OW_W    = 10;
    localparam int STEP_W  = 11;
    localparam int SUM_W   = 22;
    localparam int TAPS_W  = 6;
    localparam int LUMA_W  = 16;
    localparam int LEVEL_W = 16;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 14;
    localparam int DIV_CNT_W = 5;

    localparam logic [7:0] LUMA_WB = 8'd29;
    localparam logic [7:0] LUMA_WG = 8'd150;
    localparam logic [7:0] LUMA_WR = 8'd77;

    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TGT_WIDTH  = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [TAPS_W-1:0] taps;
    } t_col_entry;
endpackage

FILE: src/luma_area_downscaler.sv
`timescale 1ns / 1ps
`include "luma_area_downscaler_macros.svh"
// Streaming luma box downscaler. Source pixels enter in raster order, and each output pixel's
// mean BT.601 luma comes out as a Q0.16 level at the last source pixel of its block, with its
// column, row and an end-of-frame flag. Per-column partial sums live in a 512-entry memory that
// is read, updated and written back once per pixel. A pixel that closes a block also computes the
// mean and loads the output, and waits while the previous result is still held on the output.
// One that ends a column band before the row end, or ends a row band, also computes the next
// band's limit; both come from one shared 32-step radix-2 divider. A pixel that carries
// frame_start also computes the geometry.
// Geometry registers are sampled at frame_start.
module luma_area_downscaler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_blue,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_red,
    input  logic                            i_frame_start,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lds_pkg::LEVEL_W-1:0]     o_luma_level,
    output logic [lds_pkg::OCOL_W-1:0]      o_out_col,
    output logic [lds_pkg::POS_W-1:0]       o_out_row,
    output logic                            o_frame_done,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [lds_pkg::DIM_W-1:0]       i_cfg_data
);
    import lds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_GEO, S_DIV_OH, S_DIV_C0, S_DIV_R0, S_RD, S_MOD,
        S_DIV_L, S_EMIT, S_ADV, S_DIV_C, S_DIV_R
    } t_state;

    t_state r_state;

    logic [DIM_W-1:0]  r_cfg_sw, r_cfg_sh;
    logic [OW_W-1:0]   r_cfg_tw;

    logic              r_live;
    logic [DIM_W-1:0]  r_fw, r_fh, r_oh;
    logic [OW_W-1:0]   r_ow;
    logic [POS_W-1:0]  r_src_x, r_src_y, r_dst_y;
    logic [OCOL_W-1:0] r_dst_x;
    logic [POS_W-1:0]  r_col_lo, r_row_lo;
    logic [DIM_W-1:0]  r_col_hi, r_row_hi, r_col0_hi;
    logic [STEP_W-1:0] r_col_step, r_row_step, r_col0_step;
    logic [STEP_W-1:0] r_cph, r_rph;
    logic [LUMA_W-1:0] r_luma;

    logic                 r_div_go;
    logic [DIV_NUM_W-1:0] r_div_num;
    logic [DIV_DEN_W-1:0] r_div_den;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_div_q;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level, r_out_level;
    logic [OCOL_W-1:0]  r_ocol, r_out_col;
    logic [POS_W-1:0]   r_orow, r_out_row;
    logic               r_odone, r_out_done;

    t_col_entry w_rd_data, w_old, w_new;
    logic       w_wr_en;

    logic [DIM_W-1:0]  w_sw, w_sh;
    logic [OW_W-1:0]   w_tw, w_ow;
    logic [LUMA_W-1:0] w_luma;
    logic              w_first, w_tap, w_last;
    logic [DIV_DEN_W-1:0] w_den;
    logic [DIV_NUM_W-1:0] w_lnum;
    logic [DIM_W-1:0]  w_nx, w_ny;
    logic [STEP_W-1:0] w_cph_nx, w_rph_nx;
    logic [DIM_W-1:0]  w_lo, w_lo1, w_bq, w_bhi, w_bdiff;
    logic [STEP_W-1:0] w_bstep;
    logic [DIM_W-1:0]  w_ohq;
    logic [LEVEL_W-1:0] w_level;
    logic [25:0]       w_row_prod;
    logic [22:0]       w_col_prod;
    logic [22:0]       w_geo_prod;

    always_comb begin
        w_sw = (r_cfg_sw == '0) ? DIM_W'(1) :
               (r_cfg_sw > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : r_cfg_sw;
        w_sh = (r_cfg_sh == '0) ? DIM_W'(1) :
               (r_cfg_sh > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : r_cfg_sh;
        w_tw = (r_cfg_tw == '0) ? OW_W'(1) :
               (r_cfg_tw > OW_W'(MAX_OUT_WIDTH)) ? OW_W'(MAX_OUT_WIDTH) : r_cfg_tw;
        w_ow = ({{(DIM_W-OW_W){1'b0}}, w_tw} < w_sw) ? w_tw : w_sw[OW_W-1:0];
    end

    assign w_luma = LUMA_W'(LUMA_WB * i_blue) + LUMA_W'(LUMA_WG * i_green)
                  + LUMA_W'(LUMA_WR * i_red);

    assign w_first = (r_src_x == r_col_lo) && (r_src_y == r_row_lo);
    assign w_tap   = (r_cph == '0) && (r_rph == '0);
    assign w_last  = ({1'b0, r_src_x} + DIM_W'(1) == r_col_hi)
                  && ({1'b0, r_src_y} + DIM_W'(1) == r_row_hi);

    always_comb begin
        w_old = w_first ? '0 : w_rd_data;
        w_new = w_old;
        if (w_tap) begin
            w_new.sum  = w_old.sum + {{(SUM_W-LUMA_W){1'b0}}, r_luma};
            w_new.taps = w_old.taps + TAPS_W'(1);
        end
    end

    assign w_den  = {w_new.taps, 8'd0} - {8'd0, w_new.taps};
    assign w_lnum = {2'b00, w_new.sum, 8'd0} + {{(DIV_NUM_W-DIV_DEN_W+1){1'b0}},
                                                 w_den[DIV_DEN_W-1:1]};
    assign w_wr_en = (r_state == S_MOD);

    assign w_nx = {1'b0, r_src_x} + DIM_W'(1);
    assign w_ny = {1'b0, r_src_y} + DIM_W'(1);
    assign w_cph_nx = (r_cph + STEP_W'(1) == r_col_step) ? '0 : r_cph + STEP_W'(1);
    assign w_rph_nx = (r_rph + STEP_W'(1) == r_row_step) ? '0 : r_rph + STEP_W'(1);

    always_comb begin
        case (r_state)
            S_DIV_C: w_lo = {1'b0, r_col_lo};
            S_DIV_R: w_lo = {1'b0, r_row_lo};
            default: w_lo = '0;
        endcase
        w_lo1   = w_lo + DIM_W'(1);
        w_bq    = w_div_q[DIM_W-1:0];
        w_bhi   = (w_bq < w_lo1) ? w_lo1 : w_bq;
        w_bdiff = w_bhi - w_lo;
        w_bstep = (w_bdiff[DIM_W-1:2] == '0) ? STEP_W'(1) : w_bdiff[DIM_W-1:2];
        w_ohq   = (w_div_q[DIM_W-1:0] == '0) ? DIM_W'(1) : w_div_q[DIM_W-1:0];
        w_level = (w_div_q[DIV_NUM_W-1:LEVEL_W] != '0) ? '1 : w_div_q[LEVEL_W-1:0];
    end

    assign w_row_prod = ({1'b0, r_dst_y} + DIM_W'(2)) * r_fh;
    assign w_col_prod = ({1'b0, r_dst_x} + OW_W'(2)) * r_fw;
    assign w_geo_prod = r_ow * r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw <= DIM_W'(1);
            r_cfg_sh <= DIM_W'(1);
            r_cfg_tw <= OW_W'(160);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_cfg_sw <= i_cfg_data;
                CFG_SRC_HEIGHT: r_cfg_sh <= i_cfg_data;
                CFG_TGT_WIDTH:  r_cfg_tw <= i_cfg_data[OW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_luma <= w_luma;
                        if (i_frame_start) begin
                            r_fw    <= w_sw;
                            r_fh    <= w_sh;
                            r_ow    <= w_ow;
                            r_src_x <= '0;
                            r_src_y <= '0;
                            r_dst_x <= '0;
                            r_dst_y <= '0;
                            r_live  <= 1'b0;
                            r_state <= S_GEO;
                        end else if (r_live) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_GEO: begin
                    r_div_go  <= 1'b1;
                    r_div_num <= DIV_NUM_W'(w_geo_prod);
                    r_div_den <= DIV_DEN_W'(r_fw);
                    r_state   <= S_DIV_OH;
                end
                S_DIV_OH: begin
                    if (w_div_done) begin
                        r_oh      <= w_ohq;
                        r_div_go  <= 1'b1;
                        r_div_num <= DIV_NUM_W'(r_fw);
                        r_div_den <= DIV_DEN_W'(r_ow);
                        r_state   <= S_DIV_C0;
                    end
                end
                S_DIV_C0: begin
                    if (w_div_done) begin
                        r_col_lo    <= '0;
                        r_col_hi    <= w_bhi;
                        r_col_step  <= w_bstep;
                        r_col0_hi   <= w_bhi;
                        r_col0_step <= w_bstep;
                        r_cph       <= '0;
                        r_div_go    <= 1'b1;
                        r_div_num   <= DIV_NUM_W'(r_fh);
                        r_div_den   <= DIV_DEN_W'(r_oh);
                        r_state     <= S_DIV_R0;
                    end
                end
                S_DIV_R0: begin
                    if (w_div_done) begin
                        r_row_lo   <= '0;
                        r_row_hi   <= w_bhi;
                        r_row_step <= w_bstep;
                        r_rph      <= '0;
                        r_live     <= 1'b1;
                        r_state    <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_ocol  <= r_dst_x;
                    r_orow  <= r_dst_y;
                    r_odone <= ({1'b0, r_dst_x} + OW_W'(1) == r_ow)
                            && ({1'b0, r_dst_y} + DIM_W'(1) == r_oh);
                    if (!w_last) begin
                        r_state <= S_ADV;
                    end else if (w_new.taps == '0) begin
                        r_level <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_div_go  <= 1'b1;
                        r_div_num <= w_lnum;
                        r_div_den <= w_den;
                        r_state   <= S_DIV_L;
                    end
                end
                S_DIV_L: begin
                    if (w_div_done) begin
                        r_level <= w_level;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_level;
                        r_out_col   <= r_ocol;
                        r_out_row   <= r_orow;
                        r_out_done  <= r_odone;
                        r_state     <= S_ADV;
                    end
                end
                S_ADV: begin
                    if (w_nx >= r_fw) begin
                        r_src_x    <= '0;
                        r_dst_x    <= '0;
                        r_col_lo   <= '0;
                        r_col_hi   <= r_col0_hi;
                        r_col_step <= r_col0_step;
                        r_cph      <= '0;
                        if (w_ny >= r_fh) begin
                            r_live  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_src_y <= w_ny[POS_W-1:0];
                            if (w_ny >= r_row_hi) begin
                                r_dst_y   <= r_dst_y + POS_W'(1);
                                r_row_lo  <= r_row_hi[POS_W-1:0];
                                r_rph     <= '0;
                                r_div_go  <= 1'b1;
                                r_div_num <= DIV_NUM_W'(w_row_prod);
                                r_div_den <= DIV_DEN_W'(r_oh);
                                r_state   <= S_DIV_R;
                            end else begin
                                r_rph   <= w_rph_nx;
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_src_x <= w_nx[POS_W-1:0];
                        if (w_nx >= r_col_hi) begin
                            r_dst_x   <= r_dst_x + OCOL_W'(1);
                            r_col_lo  <= r_col_hi[POS_W-1:0];
                            r_cph     <= '0;
                            r_div_go  <= 1'b1;
                            r_div_num <= DIV_NUM_W'(w_col_prod);
                            r_div_den <= DIV_DEN_W'(r_ow);
                            r_state   <= S_DIV_C;
                        end else begin
                            r_cph   <= w_cph_nx;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV_C: begin
                    if (w_div_done) begin
                        r_col_hi   <= w_bhi;
                        r_col_step <= w_bstep;
                        r_state    <= S_IDLE;
                    end
                end
                S_DIV_R: begin
                    if (w_div_done) begin
                        r_row_hi   <= w_bhi;
                        r_row_step <= w_bstep;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );

    lds_colmem u_colmem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_dst_x),
        .i_wr_data (w_new),
        .i_rd_addr (r_dst_x),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_luma_level = r_out_level;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_frame_done = r_out_done;
    assign o_cfg_ready  = 1'b1;

    `LDS_CHECK(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_EMIT), "item loaded outside emit state")
    `LDS_CHECK(a_div_done_waited, i_clk, i_rst_n, w_div_done |-> (r_state == S_DIV_OH || r_state == S_DIV_C0 || r_state == S_DIV_R0 || r_state == S_DIV_L || r_state == S_DIV_C || r_state == S_DIV_R), "divider finished while no state waits for it")
    `LDS_CHECK(a_col_in_band, i_clk, i_rst_n, (r_live && r_state == S_IDLE) |-> ({1'b0, r_src_x} < r_col_hi && r_src_x >= r_col_lo), "source column outside current band")
    `LDS_CHECK_ALWAYS(a_no_go_in_reset, i_clk, !i_rst_n |=> !r_div_go, "divider started right after reset")
endmodule

FILE: src/lds_div.sv
`timescale 1ns / 1ps
module lds_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [lds_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [lds_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [lds_pkg::DIV_NUM_W-1:0]  o_quo
);
    import lds_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_rem_sh;
    logic                 w_ge;
    logic [DIV_DEN_W:0]   w_rem_sub;

    assign w_rem_sh  = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
                r_rem <= w_ge ? w_rem_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: src/lds_colmem.sv
`timescale 1ns / 1ps
module lds_colmem (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [lds_pkg::OCOL_W-1:0]  i_wr_addr,
    input  lds_pkg::t_col_entry         i_wr_data,
    input  logic [lds_pkg::OCOL_W-1:0]  i_rd_addr,
    output lds_pkg::t_col_entry         o_rd_data
);
    import lds_pkg::*;

    t_col_entry r_mem [MAX_OUT_WIDTH];
    t_col_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: dv/tb_luma_area_downscaler.sv
`timescale 1ns / 1ps
module tb_luma_area_downscaler;
    import lds_pkg::*;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } pixel_t;

    typedef struct {
        logic [LEVEL_W-1:0] luma_level;
        logic [OCOL_W-1:0]  out_col;
        logic [POS_W-1:0]   out_row;
        logic               frame_done;
    } luma_out_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_blue = '0;
    logic [7:0]         i_green = '0;
    logic [7:0]         i_red = '0;
    logic               i_frame_start = 1'b0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    logic [LEVEL_W-1:0] o_luma_level;
    logic [OCOL_W-1:0]  o_out_col;
    logic [POS_W-1:0]   o_out_row;
    logic               o_frame_done;
    logic               cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [DIM_W-1:0]   cfg_data = '0;

    luma_area_downscaler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_frame_start(i_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_luma_level (o_luma_level),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_done (o_frame_done),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    pixel_t      pixel_queue[$];
    luma_out_t   luma_expected[$];
    pixel_t      cur_pixel;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int          pushed = 0;

    // Shadow of the geometry registers and the downscaler state.
    int unsigned reg_src_w = 1, reg_src_h = 1, reg_tgt_w = 160;
    int unsigned col_sum[MAX_OUT_WIDTH];
    int unsigned col_taps[MAX_OUT_WIDTH];
    int unsigned sx, sy, dx, dy, ow, oh, fw, fh;
    int unsigned row_lo, row_hi, row_step, col_lo, col_hi, col_step;
    bit          live = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void band_limits(int unsigned d, int unsigned src, int unsigned dst,
                                        output int unsigned lo, output int unsigned hi,
                                        output int unsigned step);
        lo = d * src / dst;
        hi = (d + 1) * src / dst;
        if (hi < lo + 1) hi = lo + 1;
        step = (hi - lo) / 4;
        if (step < 1) step = 1;
    endfunction

    function automatic void predict_pixel(pixel_t p);
        int unsigned      c;
        longint unsigned  den;
        longint unsigned  level;
        luma_out_t        res;
        if (p.frame_start) begin
            fw = clamp_dim(reg_src_w, MAX_SRC_DIM);
            fh = clamp_dim(reg_src_h, MAX_SRC_DIM);
            ow = clamp_dim(reg_tgt_w, MAX_OUT_WIDTH);
            if (fw < ow) ow = fw;
            oh = ow * fh / fw;
            if (oh < 1) oh = 1;
            sx = 0; sy = 0; dx = 0; dy = 0;
            band_limits(dx, fw, ow, col_lo, col_hi, col_step);
            band_limits(dy, fh, oh, row_lo, row_hi, row_step);
            live = 1'b1;
        end
        if (!live) return;
        c = dx % MAX_OUT_WIDTH;
        if (sx == col_lo && sy == row_lo) begin
            col_sum[c] = 0;
            col_taps[c] = 0;
        end
        if ((sx - col_lo) % col_step == 0 && (sy - row_lo) % row_step == 0) begin
            col_sum[c] += 29 * p.blue + 150 * p.green + 77 * p.red;
            col_taps[c] += 1;
        end
        if (sx + 1 == col_hi && sy + 1 == row_hi) begin
            level = 0;
            if (col_taps[c] != 0) begin
                den = longint'(col_taps[c]) * 255;
                level = (longint'(col_sum[c]) * 256 + den / 2) / den;
                if (level > 65535) level = 65535;
            end
            res.luma_level = level[15:0];
            res.out_col = dx[8:0];
            res.out_row = dy[11:0];
            res.frame_done = (dx + 1 == ow && dy + 1 == oh);
            luma_expected.insert(luma_expected.size(), res);
        end
        sx++;
        if (sx >= fw) begin
            sx = 0;
            dx = 0;
            band_limits(dx, fw, ow, col_lo, col_hi, col_step);
            sy++;
            if (sy >= fh) begin
                live = 1'b0;
            end else if (sy >= row_hi) begin
                dy++;
                band_limits(dy, fh, oh, row_lo, row_hi, row_step);
            end
        end else if (sx >= col_hi) begin
            dx++;
            band_limits(dx, fw, ow, col_lo, col_hi, col_step);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && o_in_stall)) begin
            if (in_valid) begin
                predict_pixel(cur_pixel);
                gap_left = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                cur_pixel = pixel_queue.pop_front();
                in_valid <= 1'b1;
                i_blue <= cur_pixel.blue;
                i_green <= cur_pixel.green;
                i_red <= cur_pixel.red;
                i_frame_start <= cur_pixel.frame_start;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        luma_out_t want;
        int        next_stall;
        next_stall = stall_left > 0 ? stall_left - 1 : 0;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (luma_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected item: level %0d col %0d row %0d done %0d",
                             o_luma_level, o_out_col, o_out_row, o_frame_done);
            end else begin
                want = luma_expected.pop_front();
                if (o_luma_level !== want.luma_level || o_out_col !== want.out_col ||
                    o_out_row !== want.out_row || o_frame_done !== want.frame_done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 want.luma_level, want.out_col, want.out_row,
                                 want.frame_done, o_luma_level, o_out_col, o_out_row,
                                 o_frame_done);
                end
            end
            next_stall = no_idle ? 0 : $urandom_range(0, 15);
        end
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            next_stall = 400;
        end
        stall_left <= next_stall;
        out_stall <= (next_stall != 0);
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[DIM_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  reg_src_w = val & 32'h1FFF;
            CFG_SRC_HEIGHT: reg_src_h = val & 32'h1FFF;
            CFG_TGT_WIDTH:  reg_tgt_w = val & 32'h3FF;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (in_valid || pixel_queue.size() > 0 || luma_expected.size() > 0);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned tw);
        wait_drained();
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_TGT_WIDTH, tw);
    endtask

    function automatic logic [7:0] draw_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input bit fs);
        pixel_t p;
        p.blue = draw_level();
        p.green = draw_level();
        p.red = draw_level();
        p.frame_start = fs;
        pixel_queue.insert(pixel_queue.size(), p);
        pushed++;
    endtask

    task automatic push_frame(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) push_pixel(n == 0);
    endtask

    initial begin
        int unsigned w, h, tw, npix, phase_end;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_pixel(1'b0);
        push_pixel(1'b0);
        push_frame(1);
        push_frame(1);
        push_pixel(1'b0);

        set_geometry(4, 4, 16);
        push_frame(5);
        push_frame(16);

        set_geometry(16, 4, 16);
        no_idle = 1'b1;
        push_frame(64);
        hold_req++;
        wait_drained();
        no_idle = 1'b0;

        set_geometry(0, 0, 0);
        push_frame(3);
        set_geometry(8191, 1, 1023);
        push_frame(20);
        set_geometry(1, 4096, 16);
        push_frame(10);
        set_geometry(4096, 8191, 512);
        push_frame(10);

        while (pushed < 550) begin
            case ($urandom_range(0, 9))
                0: w = 8191;
                1: w = $urandom_range(0, 4);
                default: w = $urandom_range(1, 48);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(4096, 8191) : $urandom_range(1, 12);
            case ($urandom_range(0, 7))
                0: tw = 0;
                1: tw = 1023;
                default: tw = $urandom_range(16, 512);
            endcase
            if ($urandom_range(0, 7) == 0) tw = $urandom_range(0, 1023);
            set_geometry(w, h, tw);
            no_idle = ($urandom_range(0, 3) == 0);
            phase_end = pushed + $urandom_range(40, 90);
            while (pushed < phase_end) begin
                npix = clamp_dim(w, MAX_SRC_DIM) * clamp_dim(h, MAX_SRC_DIM);
                if (npix > 120) npix = $urandom_range(1, 60);
                else if ($urandom_range(0, 5) == 0) npix = $urandom_range(1, npix);
                push_frame(npix);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) push_pixel($urandom_range(0, 7) == 0);
            end
        end

        wait_drained();
        if (mismatches == 0 && luma_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/lds_pkg.sv
src/lds_div.sv
src/lds_colmem.sv
src/luma_area_downscaler.sv
dv/tb_luma_area_downscaler.sv
